[hw/rtl/isaac_pkg.sv]
// ----------------------------------------------------------------------------
// isaac_pkg
// Shared commands, constants and helper functions for the ISAAC generator.
// ----------------------------------------------------------------------------
package isaac_pkg;

  localparam logic [1:0] CMD_SEED = 2'd0;
  localparam logic [1:0] CMD_INIT = 2'd1;
  localparam logic [1:0] CMD_NEXT = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  localparam logic [31:0] GOLDEN_WORD = 32'h9e3779b9;

  localparam logic [1:0] REG_WARMUP = 2'd0;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] mix_vec_t;

  // One step of the eight-word scramble: step k (0..7) updates three words.
  function automatic mix_vec_t scramble_step(input mix_vec_t s, input logic [2:0] k);
    mix_vec_t r;
    logic [2:0] i0;
    logic [2:0] i1;
    logic [2:0] i2;
    logic [2:0] i3;
    word_t m;
    r  = s;
    i0 = k;
    i1 = k + 3'd1;
    i2 = k + 3'd2;
    i3 = k + 3'd3;
    unique case (k)
      3'd0: m = r[i1] << 11;
      3'd1: m = r[i1] >> 2;
      3'd2: m = r[i1] << 8;
      3'd3: m = r[i1] >> 16;
      3'd4: m = r[i1] << 10;
      3'd5: m = r[i1] >> 4;
      3'd6: m = r[i1] << 8;
      default: m = r[i1] >> 9;
    endcase
    r[i0] = r[i0] ^ m;
    r[i3] = r[i3] + r[i0];
    r[i1] = r[i1] + r[i2];
    return r;
  endfunction

  // Accumulator shift for the block-generation step.
  function automatic word_t acc_mix(input word_t a, input logic [1:0] ph);
    word_t m;
    unique case (ph)
      2'd0: m = a << 13;
      2'd1: m = a >> 6;
      2'd2: m = a << 2;
      default: m = a >> 16;
    endcase
    return a ^ m;
  endfunction

endpackage

[hw/rtl/isaac_mem.sv]
// ----------------------------------------------------------------------------
// isaac_mem
// Single-write, single-read synchronous word memory with registered read data.
// ----------------------------------------------------------------------------
module isaac_mem #(
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/isaac_random_generator.sv]
// ----------------------------------------------------------------------------
// isaac_random_generator
// ISAAC 32-bit pseudo-random generator with memory-based state.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  in_     | slave     | tuser: command[1:0]
//          |           | tdata: seed_index[7:0], seed_word[39:8], use_seed[40]
//  out_    | master    | tdata: random_word[31:0]
//  cfg_    | APB slave | register 0 at 0x0: warmup_enable (bit 0)
//
// One transaction is worked on at a time. A seed write goes to the result
// store in its accepting cycle. A next with words left reads the result
// store in ST_NR, waiting while an earlier result is held, and registers it
// into out_tdata in ST_NW. Block generation runs ST_BS, then ST_G0..ST_G5 per
// word: four reads and one write of the single-read-port mixing memory. Init
// scrambles the state, then runs one unseeded or two seeded fill passes (per
// group of eight words: read and add if seeded, scramble, write), then five
// blocks with warm-up on or one without. After reset a clearing pass over all
// 2^SIZE_LOG2 entries zeroes both memories while in_tready stays low. A result
// waiting on out_tready holds back only the next fetch, not seeds or inits.
// ----------------------------------------------------------------------------
module isaac_random_generator
  import isaac_pkg::*;
#(
  parameter int SIZE_LOG2 = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // command
  input  logic [47:0] in_tdata,   // seed_index, seed_word, use_seed
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // random_word
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = SIZE_LOG2;
  localparam int N  = 2**AW;

  localparam logic [4:0] ST_CLR   = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_SCR   = 5'd2;   // initial four scrambles
  localparam logic [4:0] ST_FR    = 5'd3;   // fill: issue first source read
  localparam logic [4:0] ST_FA    = 5'd4;   // fill: add source word
  localparam logic [4:0] ST_FS    = 5'd5;   // fill: scramble
  localparam logic [4:0] ST_FW    = 5'd6;   // fill: write eight words
  localparam logic [4:0] ST_BS    = 5'd7;   // block start
  localparam logic [4:0] ST_G0    = 5'd8;   // read m[i]
  localparam logic [4:0] ST_G1    = 5'd9;   // x arrives; read m[i+N/2]
  localparam logic [4:0] ST_G2    = 5'd10;  // update a; read m[x>>2]
  localparam logic [4:0] ST_G3    = 5'd11;  // write y
  localparam logic [4:0] ST_G4    = 5'd12;  // read m[y>>..]
  localparam logic [4:0] ST_G5    = 5'd13;  // b, write result
  localparam logic [4:0] ST_NR    = 5'd14;  // next: read result store
  localparam logic [4:0] ST_NW    = 5'd15;  // next: capture

  logic [4:0]    st_r, st_nxt;
  logic          warm_r;
  logic [AW:0]   left_r;
  word_t         a_r, b_r, cnt_r, x_r, y_r;
  mix_vec_t      s_r;
  logic [AW-1:0] i_r;
  logic [2:0]    k_r, stp_r;
  logic [1:0]    pass_r;      // remaining fill passes
  logic          seeded_r;
  logic [2:0]    blocks_r;    // blocks still to make in init
  logic          next_blk_r;  // block made for a next command
  logic [31:0]   out_r;
  logic          ov_r;

  // memory ports
  logic          mm_we, rs_we;
  logic [AW-1:0] mm_wa, mm_ra, rs_wa, rs_ra;
  word_t         mm_wd, rs_wd, mm_rd, rs_rd;

  isaac_mem #(.AW(AW)) u_mix (
    .clk(clk), .we(mm_we), .waddr(mm_wa), .wdata(mm_wd), .raddr(mm_ra), .rdata(mm_rd)
  );
  isaac_mem #(.AW(AW)) u_res (
    .clk(clk), .we(rs_we), .waddr(rs_wa), .wdata(rs_wd), .raddr(rs_ra), .rdata(rs_rd)
  );

  logic [1:0]    in_cmd;
  logic [7:0]    in_idx;
  word_t         in_word;
  logic          in_seed;
  assign in_cmd  = in_tuser;
  assign in_idx  = in_tdata[7:0];
  assign in_word = in_tdata[39:8];
  assign in_seed = in_tdata[40];

  assign in_tready = (st_r == ST_IDLE);
  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_WARMUP[0]) ? {31'd0, warm_r} : 32'd0;
  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  // generation datapath pieces
  logic [1:0] ph;
  word_t      a_new, y_val, b_val;
  assign ph    = i_r[1:0];
  assign a_new = acc_mix(a_r, ph) + mm_rd;
  assign y_val = mm_rd + a_r + b_r;
  assign b_val = mm_rd + x_r;

  logic [AW-1:0] half;
  assign half = i_r ^ {1'b1, {(AW-1){1'b0}}};

  // Address of word k within the current group of eight during a fill.
  logic [AW-1:0] grp_addr, grp_next;
  assign grp_addr = {i_r[AW-1:3], k_r};
  assign grp_next = {i_r[AW-1:3], k_r + 3'd1};

  always_comb begin
    st_nxt = st_r;
    mm_we = 1'b0; mm_wa = i_r; mm_wd = '0; mm_ra = i_r;
    rs_we = 1'b0; rs_wa = i_r; rs_wd = '0; rs_ra = i_r;
    unique case (st_r)
      ST_CLR: begin
        mm_we = 1'b1; rs_we = 1'b1;
        if (i_r == AW'(N - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            CMD_SEED: begin
              rs_we = 1'b1; rs_wa = AW'(in_idx); rs_wd = in_word;
            end
            CMD_INIT: st_nxt = ST_SCR;
            CMD_NEXT: st_nxt = (left_r == '0) ? ST_BS : ST_NR;
            default: st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCR: if (k_r == 3'd3 && stp_r == 3'd7) st_nxt = (seeded_r ? ST_FR : ST_FS);
      ST_FR: begin
        mm_ra = grp_addr; rs_ra = grp_addr;
        st_nxt = ST_FA;
      end
      ST_FA: begin
        mm_ra = grp_next; rs_ra = grp_next;
        st_nxt = (k_r == 3'd7) ? ST_FS : ST_FA;
      end
      ST_FS: if (stp_r == 3'd7) st_nxt = ST_FW;
      ST_FW: begin
        mm_we = 1'b1; mm_wa = grp_addr; mm_wd = s_r[k_r];
        if (k_r == 3'd7) begin
          if (i_r != AW'(N - 8)) st_nxt = seeded_r ? ST_FR : ST_FS;
          else if (pass_r > 2'd1) st_nxt = ST_FR;
          else st_nxt = ST_BS;
        end
      end
      ST_BS: st_nxt = ST_G0;
      ST_G0: begin mm_ra = i_r; st_nxt = ST_G1; end
      ST_G1: begin mm_ra = half; st_nxt = ST_G2; end
      ST_G2: begin mm_ra = x_r[AW+1:2]; st_nxt = ST_G3; end
      ST_G3: begin
        mm_we = 1'b1; mm_wd = y_val;
        st_nxt = ST_G4;
      end
      // The write of y has landed, so a read of entry i returns y.
      ST_G4: begin
        mm_ra = y_r[2*AW+1:AW+2];
        st_nxt = ST_G5;
      end
      ST_G5: begin
        rs_we = 1'b1; rs_wd = b_val;
        if (i_r == AW'(N - 1)) begin
          if (next_blk_r) st_nxt = ST_NR;
          else if (blocks_r > 3'd1) st_nxt = ST_BS;
          else st_nxt = ST_IDLE;
        end else st_nxt = ST_G0;
      end
      // A fetch waits here until any earlier result has been taken.
      ST_NR: begin
        rs_ra = left_r[AW-1:0] - AW'(1);
        if (!ov_r) st_nxt = ST_NW;
      end
      ST_NW: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLR; warm_r <= 1'b1; left_r <= '0; a_r <= '0; b_r <= '0;
      cnt_r <= '0; i_r <= '0; k_r <= '0; stp_r <= '0; ov_r <= 1'b0;
      pass_r <= '0; blocks_r <= '0; next_blk_r <= 1'b0; seeded_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_wr && cfg_paddr[2] == REG_WARMUP[0]) warm_r <= cfg_pwdata[0];
      if (st_r == ST_NW) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      unique case (st_r)
        ST_CLR: i_r <= i_r + AW'(1);
        ST_IDLE: if (in_acc) begin
          i_r <= '0; k_r <= '0; stp_r <= '0;
          if (in_cmd == CMD_INIT) begin
            a_r <= '0; b_r <= '0; cnt_r <= '0;
            s_r <= {8{GOLDEN_WORD}};
            seeded_r <= in_seed;
            pass_r <= in_seed ? 2'd2 : 2'd1;
            blocks_r <= warm_r ? 3'd5 : 3'd1;
            next_blk_r <= 1'b0;
          end else if (in_cmd == CMD_NEXT) begin
            next_blk_r <= (left_r == '0);
            if (left_r == '0) left_r <= (AW+1)'(N);
          end
        end
        ST_SCR: begin
          s_r <= scramble_step(s_r, stp_r);
          stp_r <= stp_r + 3'd1;
          if (stp_r == 3'd7) begin k_r <= k_r + 3'd1; if (k_r == 3'd3) k_r <= '0; end
        end
        ST_FR: k_r <= '0;
        ST_FA: begin
          s_r[k_r] <= s_r[k_r] + ((pass_r == 2'd2) ? rs_rd : mm_rd);
          k_r <= k_r + 3'd1;
        end
        ST_FS: begin
          s_r <= scramble_step(s_r, stp_r);
          stp_r <= stp_r + 3'd1;
          k_r <= '0;
        end
        ST_FW: begin
          k_r <= k_r + 3'd1;
          if (k_r == 3'd7) begin
            i_r <= i_r + AW'(8);
            if (i_r == AW'(N - 8)) pass_r <= pass_r - 2'd1;
          end
        end
        ST_BS: begin
          cnt_r <= cnt_r + 32'd1;
          b_r <= b_r + cnt_r + 32'd1;
          i_r <= '0;
        end
        ST_G1: x_r <= mm_rd;
        // accumulator updated when m[i+N/2] arrives
        ST_G2: a_r <= a_new;
        ST_G3: y_r <= y_val;
        ST_G5: begin
          b_r <= b_val;
          i_r <= i_r + AW'(1);
          if (i_r == AW'(N - 1)) begin
            blocks_r <= blocks_r - 3'd1;
            if (!next_blk_r && blocks_r == 3'd1) left_r <= (AW+1)'(N);
          end
        end
        ST_NR: if (!ov_r) left_r <= left_r - (AW+1)'(1);
        ST_NW: out_r <= rs_rd;
        default: ;
      endcase
    end
  end

endmodule
